// File: hw/rtl/qte_pkg.sv
// qte_pkg: shared widths, constants, item type and arctangent table
// for the quaternion to euler angle block; no dependencies
`default_nettype none

package qte_pkg;

  localparam int QUAT_W         = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int CORDIC_STAGES  = 16;

  // product and atan2 operand widths
  localparam int PW     = 2 * QUAT_W;
  localparam int ONE_SH = 2 * QUAT_FRAC_BITS;
  localparam int OPW    = (ONE_SH + 2 > 35) ? ONE_SH + 2 : 35;

  // normalized magnitude width and normalizer step counts
  localparam int RW       = 30;
  localparam int RS_STEPS = (OPW > RW) ? $clog2(OPW - RW + 1) : 0;
  localparam int LS_STEPS = 5;

  // integer square root of a value up to 2^60
  localparam int ROOT_W     = 61;
  localparam int ROOT_STEPS = 31;
  localparam int ROOT_OUT_W = 31;

  // cordic datapath
  localparam int CX_W          = RW + 3;
  localparam int Z_W           = 32;
  localparam int UNITS_PER_DEG = 6553600;
  localparam int ANG_W         = 16;
  localparam int ANG_FRAC      = 16;

  localparam logic signed [Z_W-1:0] ANG_LIM  = Z_W'(90 * UNITS_PER_DEG);
  localparam logic signed [Z_W-1:0] ANG_HALF = Z_W'(180 * UNITS_PER_DEG);
  localparam logic [Z_W-1:0]        ANG_RND  = Z_W'(32768);

  // angle unit pipeline depth: magnitude, normalize steps, cordic, rounding
  localparam int ANG_LAT = 1 + RS_STEPS + LS_STEPS + CORDIC_STAGES + 1;

  localparam int PITCH_W = 15;
  localparam logic signed [PITCH_W-1:0] PITCH_MAX = PITCH_W'(9000);
  localparam logic signed [ANG_W:0]     YAW_FULL  = 17'sd36000;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic signed [OPW-1:0] op_t;

  typedef struct packed {
    op_t  roll_y;
    op_t  roll_x;
    op_t  yaw_y;
    op_t  yaw_x;
    op_t  pitch_y;
    op_t  pitch_x;
    logic pitch_neg;
    logic pitch_clamped;
  } qte_item_t;

  // atan(2^-k) in hundredths of a degree times 2^16
  function automatic logic signed [Z_W-1:0] atan_tab(input int k);
    logic signed [Z_W-1:0] v;
    case (k)
      0:  v = 32'sd294912000;
      1:  v = 32'sd174096719;
      2:  v = 32'sd91987925;
      3:  v = 32'sd46694507;
      4:  v = 32'sd23437865;
      5:  v = 32'sd11730358;
      6:  v = 32'sd5866610;
      7:  v = 32'sd2933484;
      8:  v = 32'sd1466765;
      9:  v = 32'sd733385;
      10: v = 32'sd366693;
      11: v = 32'sd183346;
      12: v = 32'sd91673;
      13: v = 32'sd45837;
      14: v = 32'sd22918;
      15: v = 32'sd11459;
      16: v = 32'sd5730;
      17: v = 32'sd2865;
      18: v = 32'sd1432;
      19: v = 32'sd716;
      20: v = 32'sd358;
      21: v = 32'sd179;
      22: v = 32'sd90;
      23: v = 32'sd45;
      24: v = 32'sd22;
      25: v = 32'sd11;
      26: v = 32'sd6;
      27: v = 32'sd3;
      28: v = 32'sd1;
      29: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qte_front.sv
// qte_front: products, atan2 operands, pitch clamp and cosine square root
// depends on qte_pkg
`default_nettype none

module qte_front import qte_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [QUAT_W-1:0] quat_i,
  input  wire logic signed [QUAT_W-1:0] quat_j,
  input  wire logic signed [QUAT_W-1:0] quat_k,
  input  wire logic signed [QUAT_W-1:0] quat_real,
  output logic                          item_valid,
  input  wire logic                     item_full,
  output qte_item_t                     item
);

  localparam int FL = 5 + ROOT_STEPS;
  localparam int SD = FL - 2;

  localparam op_t ONE_OP = op_t'({{(OPW-ONE_SH-1){1'b0}}, 1'b1, {ONE_SH{1'b0}}});
  localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1) << (ROOT_W - 1);

  logic [FL-1:0] vld_r;
  logic          en;

  assign en         = !vld_r[FL-1] || !item_full;
  assign in_stall   = !en;
  assign item_valid = vld_r[FL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FL-2:0], in_valid};
    end
  end

  // stage 0: products
  logic signed [PW-1:0] p_ri_r, p_jk_r, p_ii_r, p_jj_r, p_rk_r, p_ij_r, p_kk_r, p_rj_r, p_ki_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ri_r <= quat_real * quat_i;
      p_jk_r <= quat_j * quat_k;
      p_ii_r <= quat_i * quat_i;
      p_jj_r <= quat_j * quat_j;
      p_rk_r <= quat_real * quat_k;
      p_ij_r <= quat_i * quat_j;
      p_kk_r <= quat_k * quat_k;
      p_rj_r <= quat_real * quat_j;
      p_ki_r <= quat_k * quat_i;
    end
  end

  // stage 1: doubled sums
  op_t roll_y_r, roll_x_r, yaw_y_r, yaw_x_r, s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      roll_y_r <= (OPW'(p_ri_r) + OPW'(p_jk_r)) <<< 1;
      roll_x_r <= ONE_OP - ((OPW'(p_ii_r) + OPW'(p_jj_r)) <<< 1);
      yaw_y_r  <= (OPW'(p_rk_r) + OPW'(p_ij_r)) <<< 1;
      yaw_x_r  <= ONE_OP - ((OPW'(p_jj_r) + OPW'(p_kk_r)) <<< 1);
      s_r      <= (OPW'(p_rj_r) - OPW'(p_ki_r)) <<< 1;
    end
  end

  // stage 2: clamp test and sine scaled to RW fraction bits
  logic [OPW-1:0] sm;
  logic [OPW-1:0] sm_shift;
  logic           clamp;
  logic [RW-1:0]  sc;
  op_t            py;

  assign sm    = s_r[OPW-1] ? OPW'(-s_r) : OPW'(s_r);
  assign clamp = sm >= OPW'(ONE_OP);

  if (ONE_SH > RW) begin : g_scale_dn
    assign sm_shift = sm >> (ONE_SH - RW);
  end else begin : g_scale_up
    assign sm_shift = sm << (RW - ONE_SH);
  end

  assign sc = clamp ? '0 : sm_shift[RW-1:0];
  assign py = op_t'({{(OPW-RW){1'b0}}, sc});

  qte_item_t     sd_r [SD];
  logic [RW-1:0] sc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0].roll_y        <= roll_y_r;
      sd_r[0].roll_x        <= roll_x_r;
      sd_r[0].yaw_y         <= yaw_y_r;
      sd_r[0].yaw_x         <= yaw_x_r;
      sd_r[0].pitch_y       <= s_r[OPW-1] ? -py : py;
      sd_r[0].pitch_x       <= '0;
      sd_r[0].pitch_neg     <= s_r[OPW-1];
      sd_r[0].pitch_clamped <= clamp;
      sc_r                  <= sc;
    end
  end

  for (genvar g = 1; g < SD; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[g] <= sd_r[g-1];
      end
    end
  end

  // stage 3 square, stage 4 one minus square
  logic [2*RW-1:0]   sq_r;
  logic [ROOT_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sc_r * sc_r;
      n_r  <= ROOT_ONE - ROOT_W'(sq_r);
    end
  end

  // digit by digit floor square root, one result bit per stage
  logic [ROOT_W-1:0] rn_r [ROOT_STEPS];
  logic [ROOT_W-1:0] rr_r [ROOT_STEPS];

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    localparam logic [ROOT_W-1:0] BITV = ROOT_W'(1) << (ROOT_W - 1 - 2 * g);
    logic [ROOT_W-1:0] n_in, r_in, trial;

    if (g == 0) begin : g_first
      assign n_in = n_r;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = rn_r[g-1];
      assign r_in = rr_r[g-1];
    end

    assign trial = r_in + BITV;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          rn_r[g] <= n_in - trial;
          rr_r[g] <= (r_in >> 1) + BITV;
        end else begin
          rn_r[g] <= n_in;
          rr_r[g] <= r_in >> 1;
        end
      end
    end
  end

  always_comb begin
    item         = sd_r[SD-1];
    item.pitch_x = op_t'({{(OPW-ROOT_OUT_W){1'b0}}, rr_r[ROOT_STEPS-1][ROOT_OUT_W-1:0]});
  end

endmodule

`default_nettype wire

// File: hw/rtl/qte_fifo.sv
// qte_fifo: short queue of operand items between front and back
// depends on qte_pkg
`default_nettype none

module qte_fifo import qte_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire qte_item_t wdata,
  output logic           full,
  input  wire logic      pop,
  output qte_item_t      rdata,
  output logic           empty
);

  qte_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign full    = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qte_angle.sv
// qte_angle: pipelined atan2 in hundredths of a degree, normalizer then
// vectoring cordic then rounding; depends on qte_pkg
`default_nettype none

module qte_angle import qte_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire op_t                y,
  input  wire op_t                x,
  output logic signed [ANG_W-1:0] angle
);

  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
  } ang_flags_t;

  localparam int NF = RS_STEPS + LS_STEPS + CORDIC_STAGES + 1;

  ang_flags_t     fl_r [NF];
  logic [OPW-1:0] mx_r [RS_STEPS+1];
  logic [OPW-1:0] my_r [RS_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r[0]      <= x[OPW-1] ? OPW'(-x) : OPW'(x);
      my_r[0]      <= y[OPW-1] ? OPW'(-y) : OPW'(y);
      fl_r[0].zero <= (x == '0) && (y == '0);
      fl_r[0].xneg <= x[OPW-1];
      fl_r[0].yneg <= y[OPW-1];
    end
  end

  for (genvar g = 1; g < NF; g++) begin : g_flags
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[g] <= fl_r[g-1];
      end
    end
  end

  // bring the larger magnitude below 2^RW
  for (genvar g = 0; g < RS_STEPS; g++) begin : g_rnorm
    localparam int S = 1 << (RS_STEPS - 1 - g);
    always_ff @(posedge clk) begin
      if (en) begin
        if (((mx_r[g] | my_r[g]) >> (RW - 1 + S)) != '0) begin
          mx_r[g+1] <= mx_r[g] >> S;
          my_r[g+1] <= my_r[g] >> S;
        end else begin
          mx_r[g+1] <= mx_r[g];
          my_r[g+1] <= my_r[g];
        end
      end
    end
  end

  // lift the larger magnitude to bit RW-1
  logic [RW-1:0] lx_r [LS_STEPS];
  logic [RW-1:0] ly_r [LS_STEPS];

  for (genvar g = 0; g < LS_STEPS; g++) begin : g_lnorm
    localparam int S = 1 << (LS_STEPS - 1 - g);
    logic [RW-1:0] vx, vy;
    if (g == 0) begin : g_first
      assign vx = mx_r[RS_STEPS][RW-1:0];
      assign vy = my_r[RS_STEPS][RW-1:0];
    end else begin : g_next
      assign vx = lx_r[g-1];
      assign vy = ly_r[g-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (((vx | vy) >> (RW - S)) == '0) begin
          lx_r[g] <= vx << S;
          ly_r[g] <= vy << S;
        end else begin
          lx_r[g] <= vx;
          ly_r[g] <= vy;
        end
      end
    end
  end

  // vectoring cordic, one rotation per stage
  logic signed [CX_W-1:0] cx_r [CORDIC_STAGES];
  logic signed [CX_W-1:0] cy_r [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_r  [CORDIC_STAGES];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATN = atan_tab(g);
    logic signed [CX_W-1:0] cx, cy;
    logic signed [Z_W-1:0]  z;
    if (g == 0) begin : g_first
      assign cx = CX_W'({1'b0, lx_r[LS_STEPS-1]});
      assign cy = CX_W'({1'b0, ly_r[LS_STEPS-1]});
      assign z  = '0;
    end else begin : g_next
      assign cx = cx_r[g-1];
      assign cy = cy_r[g-1];
      assign z  = z_r[g-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy > 0) begin
          cx_r[g] <= cx + (cy >>> g);
          cy_r[g] <= cy - (cx >>> g);
          z_r[g]  <= z + ATN;
        end else begin
          cx_r[g] <= cx - (cy >>> g);
          cy_r[g] <= cy + (cx >>> g);
          z_r[g]  <= z - ATN;
        end
      end
    end
  end

  // quadrant fold and rounding to hundredths
  logic signed [Z_W-1:0] zf, zc, a;
  logic [Z_W-1:0]        rnd;
  logic [ANG_W-1:0]      h;
  ang_flags_t            fl;

  always_comb begin
    zf = z_r[CORDIC_STAGES-1];
    fl = fl_r[NF-1];
    if (zf < 0) begin
      zc = '0;
    end else if (zf > ANG_LIM) begin
      zc = ANG_LIM;
    end else begin
      zc = zf;
    end
    a   = fl.xneg ? ANG_HALF - zc : zc;
    rnd = Z_W'(a) + ANG_RND;
    h   = rnd[ANG_FRAC +: ANG_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl.zero) begin
        angle <= '0;
      end else begin
        angle <= fl.yneg ? -$signed(h) : $signed(h);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_to_euler.sv
// quaternion_to_euler: unit quaternion in, aerospace roll/pitch/yaw out
// a beat passes the front pipeline, queue, angle pipelines and output register
// throughput one beat per cycle unless stalled; the three cordic pipelines
// run in parallel and the 31-stage square root sits in the front pipeline
// synchronous active-low reset clears valid bits, queue pointers and out_valid
// depends on qte_pkg, qte_front, qte_fifo, qte_angle
`default_nettype none

module quaternion_to_euler import qte_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [QUAT_W-1:0]  in_quat_i,
  input  wire logic signed [QUAT_W-1:0]  in_quat_j,
  input  wire logic signed [QUAT_W-1:0]  in_quat_k,
  input  wire logic signed [QUAT_W-1:0]  in_quat_real,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [ANG_W-1:0]        out_roll_angle,
  output logic signed [PITCH_W-1:0]      out_pitch_angle,
  output logic [ANG_W-1:0]               out_yaw_angle,
  output logic                           out_pitch_clamped
);

  // front: products, operand forming, pitch clamp and cosine root
  qte_item_t f_item;
  logic      f_valid;
  logic      q_full, q_empty, q_pop;
  qte_item_t q_head;

  qte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .quat_i     (in_quat_i),
    .quat_j     (in_quat_j),
    .quat_k     (in_quat_k),
    .quat_real  (in_quat_real),
    .item_valid (f_valid),
    .item_full  (q_full),
    .item       (f_item)
  );

  // decoupling queue, front stalls only when it is full
  qte_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .wdata (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // back pipeline moves as a whole unless the output beat is held
  logic back_en;
  logic out_valid_r;

  assign back_en = !(out_valid_r && out_stall);
  assign q_pop   = back_en && !q_empty;

  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;

  qte_angle u_roll (
    .clk   (clk),
    .en    (back_en),
    .y     (q_head.roll_y),
    .x     (q_head.roll_x),
    .angle (roll_a)
  );

  qte_angle u_pitch (
    .clk   (clk),
    .en    (back_en),
    .y     (q_head.pitch_y),
    .x     (q_head.pitch_x),
    .angle (pitch_a)
  );

  qte_angle u_yaw (
    .clk   (clk),
    .en    (back_en),
    .y     (q_head.yaw_y),
    .x     (q_head.yaw_x),
    .angle (yaw_a)
  );

  // valid and pitch clamp info ride alongside the angle pipelines
  logic [ANG_LAT-1:0] bv_r;
  logic [ANG_LAT-1:0] cl_r;
  logic [ANG_LAT-1:0] pn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (back_en) begin
      bv_r <= {bv_r[ANG_LAT-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      cl_r <= {cl_r[ANG_LAT-2:0], q_head.pitch_clamped};
      pn_r <= {pn_r[ANG_LAT-2:0], q_head.pitch_neg};
    end
  end

  // yaw into 0..35999: negative gets a full turn, a full turn wraps to 0
  logic signed [ANG_W:0]        yaw_w;
  logic [ANG_W-1:0]             yaw_nxt;
  logic signed [PITCH_W-1:0]    pitch_nxt;

  always_comb begin
    yaw_w = {yaw_a[ANG_W-1], yaw_a};
    if (yaw_w < 0) begin
      yaw_w = yaw_w + YAW_FULL;
    end
    if (yaw_w >= YAW_FULL) begin
      yaw_w = '0;
    end
    yaw_nxt = yaw_w[ANG_W-1:0];
    // forced pitch when the sine magnitude reached one
    if (cl_r[ANG_LAT-1]) begin
      pitch_nxt = pn_r[ANG_LAT-1] ? -PITCH_MAX : PITCH_MAX;
    end else begin
      pitch_nxt = pitch_a[PITCH_W-1:0];
    end
  end

  // output register, holds the beat while stalled
  logic signed [ANG_W-1:0]   roll_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic [ANG_W-1:0]          yaw_r;
  logic                      clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      out_valid_r <= bv_r[ANG_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      roll_r    <= roll_a;
      pitch_r   <= pitch_nxt;
      yaw_r     <= yaw_nxt;
      clamped_r <= cl_r[ANG_LAT-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_roll_angle    = roll_r;
  assign out_pitch_angle   = pitch_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_clamped = clamped_r;

endmodule

`default_nettype wire
